FILE: hw/rtl/pvd_pkg.sv
// shared constants, command and status types for the pairwise vector distance block
package pvd_pkg;

   localparam int MAX_LENGTH_DEF    = 4096;
   localparam int ELEMENT_WIDTH_DEF = 16;
   localparam int FRAC_W            = 16;
   localparam int DIST_W            = 40;
   localparam int KW                = FRAC_W + 1;
   localparam int SKW               = FRAC_W + 3;
   localparam int METRIC_W          = 2;
   localparam int OP_W              = 4;

   localparam logic [METRIC_W-1:0] METRIC_EUCLID   = 2'd0;
   localparam logic [METRIC_W-1:0] METRIC_MISMATCH = 2'd1;
   localparam logic [METRIC_W-1:0] METRIC_CORR     = 2'd2;

   localparam logic [OP_W-1:0] OP_VA1 = 4'd0;
   localparam logic [OP_W-1:0] OP_VA2 = 4'd1;
   localparam logic [OP_W-1:0] OP_VB1 = 4'd2;
   localparam logic [OP_W-1:0] OP_VB2 = 4'd3;
   localparam logic [OP_W-1:0] OP_CU1 = 4'd4;
   localparam logic [OP_W-1:0] OP_CU2 = 4'd5;
   localparam logic [OP_W-1:0] OP_PP  = 4'd6;
   localparam logic [OP_W-1:0] OP_CC  = 4'd7;
   localparam logic [OP_W-1:0] OP_K2  = 4'd8;
   localparam logic [OP_W-1:0] OP_KP  = 4'd9;

   typedef struct packed {
      logic            mul_start;
      logic [OP_W-1:0] mul_op;
      logic            root_start;
      logic            div_start;
      logic            chk;
      logic            step;
      logic            load_rsp;
   } pvd_cmd_type;

   typedef struct packed {
      logic                last_eff;
      logic                mul_done;
      logic                root_done;
      logic                div_done;
      logic                var_zero;
      logic                search_done;
      logic                quick;
      logic                rsp_busy;
      logic [METRIC_W-1:0] metric;
   } pvd_sts_type;

   function automatic int pvd_max(int x, int y);
      return (x > y) ? x : y;
   endfunction

endpackage

FILE: hw/rtl/pvd_mul.sv
// shift-add multiplier, one multiplier bit per cycle, stops when the remaining bits are zero
module pvd_mul import pvd_pkg::*; #(
   parameter int MCW = 116,
   parameter int YW  = 58
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [MCW-1:0]     mcand,
   input  logic [YW-1:0]      mplier,
   output logic               done,
   output logic [MCW+YW-1:0]  product
);

   localparam int MPW = MCW + YW;

   logic [MPW-1:0] acc_ff, acc_in;
   logic [MPW-1:0] mc_ff, mc_in;
   logic [YW-1:0]  my_ff, my_in;
   logic           run_ff, run_in;
   logic           done_ff, done_in;

   always_comb begin
      acc_in  = acc_ff;
      mc_in   = mc_ff;
      my_in   = my_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start && !run_ff) begin
         acc_in = '0;
         mc_in  = MPW'(mcand);
         my_in  = mplier;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (my_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            if (my_ff[0]) acc_in = acc_ff + mc_ff;
            mc_in = mc_ff << 1;
            my_in = my_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
      my_ff  <= my_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

FILE: hw/rtl/pvd_root.sv
// integer square root, two radicand bits per cycle
module pvd_root import pvd_pkg::*; #(
   parameter int IW = 62
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [IW-1:0]   radicand,
   output logic            done,
   output logic [IW/2-1:0] root
);

   localparam int RW  = IW / 2;
   localparam int REW = RW + 3;
   localparam int CNW = $clog2(RW + 1);

   logic [IW-1:0]  x_ff, x_in;
   logic [REW-1:0] rem_ff, rem_in;
   logic [RW-1:0]  root_ff, root_in;
   logic [CNW-1:0] cnt_ff, cnt_in;
   logic           run_ff, run_in;
   logic           done_ff, done_in;
   logic [REW-1:0] rem_sh, trial;

   assign rem_sh = {rem_ff[RW:0], x_ff[IW-1:IW-2]};
   assign trial  = REW'({root_ff, 2'b01});

   always_comb begin
      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start && !run_ff) begin
         x_in    = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         x_in = x_ff << 2;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[RW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNW'(RW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

FILE: hw/rtl/pvd_datapath.sv
// accumulators, finishing arithmetic, search registers and result register
module pvd_datapath import pvd_pkg::*; #(
   parameter int MAX_LENGTH    = MAX_LENGTH_DEF,
   parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [ELEMENT_WIDTH-1:0] elem_a,
   input  logic [ELEMENT_WIDTH-1:0] elem_b,
   input  logic                     last_element,
   input  logic                     csr_valid,
   input  logic [METRIC_W-1:0]      csr_metric,
   input  logic                     rsp_stall,
   input  pvd_cmd_type              cmd,
   output pvd_sts_type              sts,
   output logic                     rsp_valid,
   output logic [DIST_W-1:0]        rsp_distance,
   output logic                     rsp_undefined
);

   localparam int EW  = ELEMENT_WIDTH;
   localparam int CW  = $clog2(MAX_LENGTH + 1);
   localparam int SW  = EW + CW;
   localparam int QW  = 2 * EW;
   localparam int AAW = QW + CW;
   localparam int VW  = CW + AAW;
   localparam int MCW = 2 * VW;
   localparam int YW  = pvd_max(VW, 2 * KW);
   localparam int MPW = MCW + YW;
   localparam int RIN = ((AAW + FRAC_W + 1) / 2) * 2;
   localparam int RQ  = RIN / 2;
   localparam int DVW = CW + FRAC_W;
   localparam int DCW = $clog2(DVW + 1);
   localparam int EXW = pvd_max(pvd_max(RQ, DVW), pvd_max(SKW, DIST_W)) + 1;
   localparam logic [CW-1:0]         LAST_CNT = CW'(MAX_LENGTH - 1);
   localparam logic signed [SKW-1:0] K_ONE    = SKW'(2 ** FRAC_W);
   localparam logic [EXW-1:0]        SAT_MAX  = EXW'({DIST_W{1'b1}});

   // configuration
   logic [METRIC_W-1:0] metric_ff;

   // input pipeline
   logic                 s1_vld_ff, s2_vld_ff;
   logic signed [EW-1:0] s1_a_ff, s1_b_ff, s2_a_ff, s2_b_ff;
   logic [CW-1:0]        cnt_ff, n_ff;
   logic signed [QW-1:0] aa_w, bb_w, ab_w;
   logic signed [EW:0]   d_w;
   logic signed [2*EW+1:0] dd_w;
   logic [QW-1:0]        aa_ff, bb_ff, dd_ff;
   logic signed [QW-1:0] ab_ff;
   logic                 neq_ff;
   logic                 last_eff;

   // running sums
   logic signed [SW-1:0]  sum_a_ff, sum_b_ff;
   logic [AAW-1:0]        sum_aa_ff, sum_bb_ff, sum_sd_ff;
   logic signed [AAW-1:0] sum_ab_ff;
   logic [CW-1:0]         mm_ff;

   // finishing arithmetic
   logic [SW-1:0]      sa_u, sb_u, sa_mag, sb_mag;
   logic [AAW-1:0]     sab_u, sab_mag;
   logic [OP_W-1:0]    op_ff;
   logic [MCW-1:0]     mc_sel;
   logic [YW-1:0]      my_sel;
   logic               mul_done;
   logic [MPW-1:0]     mul_prod;
   logic [VW-1:0]      t_ff, va_ff, vb_ff, cmag_ff;
   logic               cneg_ff;
   logic [MCW-1:0]     p_ff, c2_ff;
   logic [MPW-1:0]     l_ff, r_w;
   logic [VW+1:0]      t_ext, p_ext;
   logic signed [VW+1:0] tv_w, pv_w, cu_w, cu_abs;
   logic [VW-1:0]      cu_mag;

   // correlation search
   logic signed [SKW-1:0] lo_ff, hi_ff, mid_w;
   logic                  kneg;
   logic [KW-1:0]         kmag;
   logic                  quick, ge_w;
   logic                  und_ff;

   // euclidean root and mismatch divider
   logic               root_done;
   logic [RQ-1:0]      root_val;
   logic [DVW-1:0]     dq_ff;
   logic [CW-1:0]      dr_ff;
   logic [CW:0]        dr_sh;
   logic [DCW-1:0]     dcnt_ff;
   logic               drun_ff, ddone_ff;

   // result
   logic [SKW-1:0]     corr_w;
   logic [EXW-1:0]     res_w;
   logic               rsp_valid_ff;
   logic [DIST_W-1:0]  rsp_dist_ff;
   logic               rsp_und_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         metric_ff <= METRIC_EUCLID;
      end else if (csr_valid) begin
         metric_ff <= csr_metric;
      end
   end

   assign last_eff = last_element || (cnt_ff == LAST_CNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (accept) begin
         cnt_ff <= last_eff ? '0 : cnt_ff + 1'b1;
      end
      if (accept && last_eff) n_ff <= cnt_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
         s2_vld_ff <= s1_vld_ff;
      end
      if (accept) begin
         s1_a_ff <= elem_a;
         s1_b_ff <= elem_b;
      end
      s2_a_ff <= s1_a_ff;
      s2_b_ff <= s1_b_ff;
      aa_ff   <= aa_w;
      bb_ff   <= bb_w;
      ab_ff   <= ab_w;
      dd_ff   <= dd_w[QW-1:0];
      neq_ff  <= (s1_a_ff != s1_b_ff);
   end

   assign aa_w = s1_a_ff * s1_a_ff;
   assign bb_w = s1_b_ff * s1_b_ff;
   assign ab_w = s1_a_ff * s1_b_ff;
   assign d_w  = {s1_a_ff[EW-1], s1_a_ff} - {s1_b_ff[EW-1], s1_b_ff};
   assign dd_w = d_w * d_w;

   always_ff @(posedge clock) begin
      if (reset || cmd.load_rsp) begin
         sum_a_ff  <= '0;
         sum_b_ff  <= '0;
         sum_aa_ff <= '0;
         sum_bb_ff <= '0;
         sum_ab_ff <= '0;
         sum_sd_ff <= '0;
         mm_ff     <= '0;
      end else if (s2_vld_ff) begin
         sum_a_ff  <= sum_a_ff + {{CW{s2_a_ff[EW-1]}}, s2_a_ff};
         sum_b_ff  <= sum_b_ff + {{CW{s2_b_ff[EW-1]}}, s2_b_ff};
         sum_aa_ff <= sum_aa_ff + {{CW{1'b0}}, aa_ff};
         sum_bb_ff <= sum_bb_ff + {{CW{1'b0}}, bb_ff};
         sum_ab_ff <= sum_ab_ff + {{CW{ab_ff[QW-1]}}, ab_ff};
         sum_sd_ff <= sum_sd_ff + {{CW{1'b0}}, dd_ff};
         mm_ff     <= mm_ff + {{(CW-1){1'b0}}, neq_ff};
      end
   end

   assign sa_u    = sum_a_ff;
   assign sb_u    = sum_b_ff;
   assign sab_u   = sum_ab_ff;
   assign sa_mag  = sa_u[SW-1] ? (~sa_u + 1'b1) : sa_u;
   assign sb_mag  = sb_u[SW-1] ? (~sb_u + 1'b1) : sb_u;
   assign sab_mag = sab_u[AAW-1] ? (~sab_u + 1'b1) : sab_u;

   always_comb begin
      unique case (cmd.mul_op)
         OP_VA1:  begin mc_sel = MCW'(sum_aa_ff); my_sel = YW'(n_ff);   end
         OP_VA2:  begin mc_sel = MCW'(sa_mag);    my_sel = YW'(sa_mag); end
         OP_VB1:  begin mc_sel = MCW'(sum_bb_ff); my_sel = YW'(n_ff);   end
         OP_VB2:  begin mc_sel = MCW'(sb_mag);    my_sel = YW'(sb_mag); end
         OP_CU1:  begin mc_sel = MCW'(sab_mag);   my_sel = YW'(n_ff);   end
         OP_CU2:  begin mc_sel = MCW'(sa_mag);    my_sel = YW'(sb_mag); end
         OP_PP:   begin mc_sel = MCW'(va_ff);     my_sel = YW'(vb_ff);  end
         OP_CC:   begin mc_sel = MCW'(cmag_ff);   my_sel = YW'(cmag_ff); end
         OP_K2:   begin mc_sel = MCW'(kmag);      my_sel = YW'(kmag);   end
         OP_KP:   begin mc_sel = p_ff;            my_sel = mul_prod[YW-1:0]; end
         default: begin mc_sel = '0;              my_sel = '0;          end
      endcase
   end

   pvd_mul #(
      .MCW (MCW),
      .YW  (YW)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .mcand   (mc_sel),
      .mplier  (my_sel),
      .done    (mul_done),
      .product (mul_prod)
   );

   assign t_ext  = {2'b00, t_ff};
   assign p_ext  = {2'b00, mul_prod[VW-1:0]};
   assign tv_w   = sab_u[AAW-1] ? -$signed(t_ext) : $signed(t_ext);
   assign pv_w   = (sa_u[SW-1] ^ sb_u[SW-1]) ? -$signed(p_ext) : $signed(p_ext);
   assign cu_w   = tv_w - pv_w;
   assign cu_abs = cu_w[VW+1] ? -cu_w : cu_w;
   assign cu_mag = cu_abs[VW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.mul_start) op_ff <= cmd.mul_op;
      if (mul_done) begin
         unique case (op_ff)
            OP_VA1, OP_VB1, OP_CU1: t_ff <= mul_prod[VW-1:0];
            OP_VA2: va_ff <= t_ff - mul_prod[VW-1:0];
            OP_VB2: vb_ff <= t_ff - mul_prod[VW-1:0];
            OP_CU2: begin
               cneg_ff <= cu_w[VW+1];
               cmag_ff <= cu_mag;
            end
            OP_PP:  p_ff  <= mul_prod[MCW-1:0];
            OP_CC:  c2_ff <= mul_prod[MCW-1:0];
            OP_KP:  l_ff  <= mul_prod;
            default: ;
         endcase
      end
   end

   // smallest k with k * sqrt(va * vb) >= 2^16 * cov
   assign mid_w = lo_ff + ((hi_ff - lo_ff) >>> 1);
   assign kneg  = mid_w[SKW-1];
   assign kmag  = kneg ? KW'(-mid_w) : KW'(mid_w);
   assign quick = (!kneg && (cneg_ff || (cmag_ff == '0))) || (kneg && !cneg_ff);
   assign r_w   = MPW'(c2_ff) << (2 * FRAC_W);
   assign ge_w  = quick ? !kneg : (kneg ? (l_ff <= r_w) : (l_ff >= r_w));

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff <= '0;
         hi_ff <= '0;
      end else if (cmd.chk) begin
         lo_ff <= -K_ONE;
         hi_ff <= K_ONE;
      end else if (cmd.step) begin
         if (ge_w) hi_ff <= mid_w;
         else      lo_ff <= mid_w + 1'b1;
      end
      if (cmd.chk) und_ff <= (va_ff == '0) || (vb_ff == '0);
   end

   pvd_root #(
      .IW (RIN)
   ) u_root (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.root_start),
      .radicand (RIN'({sum_sd_ff, {FRAC_W{1'b0}}})),
      .done     (root_done),
      .root     (root_val)
   );

   assign dr_sh = {dr_ff, dq_ff[DVW-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         drun_ff  <= 1'b0;
         ddone_ff <= 1'b0;
      end else begin
         ddone_ff <= 1'b0;
         if (cmd.div_start && !drun_ff) begin
            drun_ff <= 1'b1;
         end else if (drun_ff && (dcnt_ff == DCW'(DVW - 1))) begin
            drun_ff  <= 1'b0;
            ddone_ff <= 1'b1;
         end
      end
      if (cmd.div_start && !drun_ff) begin
         dq_ff   <= {mm_ff, {FRAC_W{1'b0}}};
         dr_ff   <= '0;
         dcnt_ff <= '0;
      end else if (drun_ff) begin
         dcnt_ff <= dcnt_ff + 1'b1;
         if (dr_sh >= {1'b0, n_ff}) begin
            dr_ff <= CW'(dr_sh - {1'b0, n_ff});
            dq_ff <= {dq_ff[DVW-2:0], 1'b1};
         end else begin
            dr_ff <= dr_sh[CW-1:0];
            dq_ff <= {dq_ff[DVW-2:0], 1'b0};
         end
      end
   end

   assign corr_w = K_ONE - lo_ff;

   always_comb begin
      unique case (metric_ff)
         METRIC_EUCLID:   res_w = EXW'(root_val);
         METRIC_MISMATCH: res_w = EXW'(dq_ff);
         METRIC_CORR:     res_w = und_ff ? '0 : EXW'(corr_w);
         default:         res_w = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_dist_ff <= (res_w > SAT_MAX) ? {DIST_W{1'b1}} : res_w[DIST_W-1:0];
         rsp_und_ff  <= (metric_ff == METRIC_CORR) && und_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_distance  = rsp_dist_ff;
   assign rsp_undefined = rsp_und_ff;

   always_comb begin
      sts.last_eff    = last_eff;
      sts.mul_done    = mul_done;
      sts.root_done   = root_done;
      sts.div_done    = ddone_ff;
      sts.var_zero    = (va_ff == '0) || (vb_ff == '0);
      sts.search_done = (lo_ff >= hi_ff);
      sts.quick       = quick;
      sts.rsp_busy    = rsp_valid_ff && rsp_stall;
      sts.metric      = metric_ff;
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |=> !(cmd.root_start || cmd.div_start))
      else $error("root or divide started right after a multiply");

endmodule

FILE: hw/rtl/pvd_ctrl.sv
// sequencer: collection, pipeline drain, metric finish and result hand-off
module pvd_ctrl import pvd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  pvd_sts_type sts,
   output pvd_cmd_type cmd,
   output logic        req_stall
);

   localparam logic [3:0] S_COLLECT  = 4'd0;
   localparam logic [3:0] S_DRAIN1   = 4'd1;
   localparam logic [3:0] S_DRAIN2   = 4'd2;
   localparam logic [3:0] S_DISPATCH = 4'd3;
   localparam logic [3:0] S_ROOT     = 4'd4;
   localparam logic [3:0] S_DIV      = 4'd5;
   localparam logic [3:0] S_MUL      = 4'd6;
   localparam logic [3:0] S_CHK      = 4'd7;
   localparam logic [3:0] S_SEARCH   = 4'd8;
   localparam logic [3:0] S_CMP      = 4'd9;
   localparam logic [3:0] S_OUT      = 4'd10;

   logic [3:0]      state_ff, state_in;
   logic [OP_W-1:0] op_ff, op_in;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cmd      = '0;
      unique case (state_ff)
         S_COLLECT: if (accept && sts.last_eff) state_in = S_DRAIN1;
         S_DRAIN1:  state_in = S_DRAIN2;
         S_DRAIN2:  state_in = S_DISPATCH;
         S_DISPATCH: begin
            unique case (sts.metric)
               METRIC_EUCLID: begin
                  cmd.root_start = 1'b1;
                  state_in       = S_ROOT;
               end
               METRIC_MISMATCH: begin
                  cmd.div_start = 1'b1;
                  state_in      = S_DIV;
               end
               METRIC_CORR: begin
                  cmd.mul_start = 1'b1;
                  cmd.mul_op    = OP_VA1;
                  op_in         = OP_VA1;
                  state_in      = S_MUL;
               end
               default: state_in = S_OUT;
            endcase
         end
         S_ROOT: if (sts.root_done) state_in = S_OUT;
         S_DIV:  if (sts.div_done) state_in = S_OUT;
         S_MUL: begin
            if (sts.mul_done) begin
               unique case (op_ff)
                  OP_VA1: begin cmd.mul_start = 1'b1; op_in = OP_VA2; end
                  OP_VA2: begin cmd.mul_start = 1'b1; op_in = OP_VB1; end
                  OP_VB1: begin cmd.mul_start = 1'b1; op_in = OP_VB2; end
                  OP_VB2: begin cmd.mul_start = 1'b1; op_in = OP_CU1; end
                  OP_CU1: begin cmd.mul_start = 1'b1; op_in = OP_CU2; end
                  OP_CU2: state_in = S_CHK;
                  OP_PP:  begin cmd.mul_start = 1'b1; op_in = OP_CC; end
                  OP_CC:  state_in = S_SEARCH;
                  OP_K2:  begin cmd.mul_start = 1'b1; op_in = OP_KP; end
                  default: state_in = S_CMP;
               endcase
               cmd.mul_op = op_in;
            end
         end
         S_CHK: begin
            cmd.chk = 1'b1;
            if (sts.var_zero) begin
               state_in = S_OUT;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_op    = OP_PP;
               op_in         = OP_PP;
               state_in      = S_MUL;
            end
         end
         S_SEARCH: begin
            if (sts.search_done) begin
               state_in = S_OUT;
            end else if (sts.quick) begin
               cmd.step = 1'b1;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_op    = OP_K2;
               op_in         = OP_K2;
               state_in      = S_MUL;
            end
         end
         S_CMP: begin
            cmd.step = 1'b1;
            state_in = S_SEARCH;
         end
         S_OUT: begin
            if (!sts.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_COLLECT;
            end
         end
         default: state_in = S_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_COLLECT;
         op_ff    <= OP_VA1;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   assign req_stall = (state_ff != S_COLLECT);

   assert property (@(posedge clock) disable iff (reset)
      (accept && sts.last_eff) |=> req_stall)
      else $error("item taken after the last pair of a vector");

   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !sts.rsp_busy)
      else $error("result register overwritten while held");

   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.mul_start, cmd.root_start, cmd.div_start, cmd.load_rsp, cmd.step}))
      else $error("conflicting datapath commands");

endmodule

FILE: hw/rtl/pairwise_vector_distance.sv
// top level: pairwise vector distance, euclidean, mismatch fraction or correlation
//
//   channel   dir   handshake          payload
//   req       in    req_valid/stall    elem_a, elem_b, last_element
//   rsp       out   rsp_valid/stall    distance (Q24.16, euclidean Q32.8), undefined
//   csr       in    csr_valid/ready    metric
//
// one item per cycle is taken while a vector streams in; the last pair (or the
// MAX_LENGTH-th) holds req_stall high through the drain states and the finish:
// euclidean in the root unit, mismatch in the divider, correlation six shift-add
// multiplies when a variance is zero, else eight plus two per search step that the
// quick sign test does not settle, with up to 18 steps.
// reset is synchronous; the finished item waits in the output register while
// the next vector streams in.
module pairwise_vector_distance import pvd_pkg::*; #(
   parameter int MAX_LENGTH    = MAX_LENGTH_DEF,
   parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [ELEMENT_WIDTH-1:0] req_elem_a,
   input  logic [ELEMENT_WIDTH-1:0] req_elem_b,
   input  logic                     req_last_element,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [DIST_W-1:0]        rsp_distance,
   output logic                     rsp_undefined,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [METRIC_W-1:0]      csr_metric
);

   pvd_cmd_type cmd;
   pvd_sts_type sts;
   logic        accept;

   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   pvd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .sts       (sts),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   pvd_datapath #(
      .MAX_LENGTH    (MAX_LENGTH),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .elem_a        (req_elem_a),
      .elem_b        (req_elem_b),
      .last_element  (req_last_element),
      .csr_valid     (csr_valid),
      .csr_metric    (csr_metric),
      .rsp_stall     (rsp_stall),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_valid     (rsp_valid),
      .rsp_distance  (rsp_distance),
      .rsp_undefined (rsp_undefined)
   );

endmodule
